@@ hw/rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, quiet while in reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// condition that must never be seen at a clock edge
`define ASSERT_NEVER(lbl, cond, msg) \
    `ASSERT_CLK(lbl, !(cond), msg)

`endif

@@ hw/rtl/fdss_pkg.sv @@
package fdss_pkg;

    localparam int VALUE_W = 14;
    localparam int MODE_W  = 2;
    localparam int CMD_W   = 12;
    localparam int DIGIT_W = 4;
    localparam int SEG_W   = 8;

    localparam logic [VALUE_W-1:0] VALUE_MAX   = 14'd9999;
    localparam logic [DIGIT_W-1:0] DIGIT_BLANK = 4'd10;
    localparam logic [SEG_W-1:0]   POINT_BIT   = 8'h80;
    localparam logic [3:0]         CMD_BASE    = 4'h8;

    localparam logic [MODE_W-1:0] MODE_NONE      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SKIP_TENS = 2'd3;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        P_THOU = 2'd0,
        P_HUND = 2'd1,
        P_TENS = 2'd2,
        P_ONES = 2'd3
    } t_pos;

    typedef enum logic {
        FS_IDLE = 1'b0,
        FS_BUSY = 1'b1
    } t_front_state;

    typedef struct packed {
        logic [DIGIT_W-1:0] thou;
        logic [DIGIT_W-1:0] hund;
        logic [DIGIT_W-1:0] tens;
        logic [DIGIT_W-1:0] ones;
        logic [MODE_W-1:0]  mode;
    } t_entry;

    typedef struct packed {
        logic   push;
        t_entry entry;
    } t_q_wr;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_q_rd;

    function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0:    s = 8'h3f;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5b;
            4'd3:    s = 8'h4f;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6d;
            4'd6:    s = 8'h7d;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7f;
            4'd9:    s = 8'h6f;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

@@ hw/rtl/four_digit_seven_segment_commands_core.sv @@
// Turns a binary value (clamped to 9999) and a decimal-point mode into display
// digit-write words, thousands first and ones last, with leading zeros blanked;
// last_of_run marks the ones word. The front end takes a value and extracts one
// decimal digit per cycle; it takes a new value only when idle or as it pushes
// the last one into its two-entry queue, and waits while that queue is full.
// The back end issues one command word per cycle while its queue has an entry
// and the output is not stalled, through a registered output, 4 words per value
// (3 in point mode 3), the first once the value has passed the digit steps and the queue.
module four_digit_seven_segment_commands_core
    import fdss_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [VALUE_W-1:0] i_display_value,
    input  logic [MODE_W-1:0]  i_point_mode,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [CMD_W-1:0]   o_command_word,
    output logic               o_last_of_run
);

    t_q_wr q_wr;
    t_q_rd q_rd;
    logic  q_full;
    logic  q_pop;

    fdss_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_display_value (i_display_value),
        .i_point_mode    (i_point_mode),
        .i_q_full        (q_full),
        .o_q_wr          (q_wr)
    );

    fdss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .o_full  (q_full),
        .o_rd    (q_rd),
        .i_pop   (q_pop)
    );

    fdss_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rd           (q_rd),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_command_word (o_command_word),
        .o_last_of_run  (o_last_of_run)
    );

endmodule

@@ hw/rtl/fdss_front.sv @@
module fdss_front
    import fdss_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [VALUE_W-1:0] i_display_value,
    input  logic [MODE_W-1:0]  i_point_mode,
    input  logic               i_q_full,
    output t_q_wr              o_q_wr
);

    t_front_state       r_state, n_state;
    logic [1:0]         r_step, n_step;
    logic [VALUE_W-1:0] r_rem, n_rem;
    logic [DIGIT_W-1:0] r_thou, n_thou;
    logic [DIGIT_W-1:0] r_hund, n_hund;
    logic [MODE_W-1:0]  r_mode, n_mode;

    logic [VALUE_W-1:0] scale;
    logic [DIGIT_W-1:0] digit;
    logic [VALUE_W-1:0] new_rem;
    logic               last_step;
    logic               push;
    logic               accept;
    t_entry             entry;

    // one decimal digit per cycle, by parallel threshold compares
    always_comb begin
        case (r_step)
            2'd0:    scale = 14'd1000;
            2'd1:    scale = 14'd100;
            default: scale = 14'd10;
        endcase
        digit = '0;
        for (int k = 1; k < 10; k++) begin
            if (r_rem >= VALUE_W'(k) * scale) begin
                digit = DIGIT_W'(k);
            end
        end
        new_rem = r_rem - VALUE_W'(digit) * scale;
    end

    // leading zero blanking
    always_comb begin
        entry.mode = r_mode;
        entry.ones = new_rem[DIGIT_W-1:0];
        entry.tens = digit;
        entry.hund = r_hund;
        entry.thou = r_thou;
        if (r_thou == '0) begin
            entry.thou = DIGIT_BLANK;
            if (r_hund == '0) begin
                entry.hund = DIGIT_BLANK;
                if (digit == '0 && r_mode == MODE_NONE) begin
                    entry.tens = DIGIT_BLANK;
                end
            end
        end
    end

    assign last_step = (r_step == 2'd2);
    assign push      = (r_state == FS_BUSY) && last_step && !i_q_full;
    assign o_stall   = (r_state == FS_BUSY) && !push;
    assign accept    = i_valid && !o_stall;

    assign o_q_wr.push  = push;
    assign o_q_wr.entry = entry;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_rem   = r_rem;
        n_thou  = r_thou;
        n_hund  = r_hund;
        n_mode  = r_mode;
        if (accept) begin
            n_state = FS_BUSY;
            n_step  = 2'd0;
            n_rem   = (i_display_value > VALUE_MAX) ? VALUE_MAX : i_display_value;
            n_mode  = i_point_mode;
        end else if (push) begin
            n_state = FS_IDLE;
        end else if (r_state == FS_BUSY && !last_step) begin
            n_step = r_step + 2'd1;
            n_rem  = new_rem;
            if (r_step == 2'd0) begin
                n_thou = digit;
            end else begin
                n_hund = digit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
            r_step  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_thou <= n_thou;
        r_hund <= n_hund;
        r_mode <= n_mode;
    end

endmodule

@@ hw/rtl/fdss_queue.sv @@
`include "assert_macros.svh"

module fdss_queue
    import fdss_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_q_wr i_wr,
    output logic  o_full,
    output t_q_rd o_rd,
    input  logic  i_pop
);

    t_entry            r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              do_pop;

    assign o_full       = (r_count == QCNT_W'(QDEPTH));
    assign o_rd.valid   = (r_count != '0);
    assign o_rd.entry   = r_mem[r_rd_ptr];
    assign do_pop       = i_pop && o_rd.valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_wr.push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_wr.push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_wr.push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.push) begin
            r_mem[r_wr_ptr] <= i_wr.entry;
        end
    end

    `ASSERT_NEVER(a_push_when_full, o_full && i_wr.push, "queue written while full")
    `ASSERT_NEVER(a_count_range, r_count > QCNT_W'(QDEPTH), "queue count out of range")
    `ASSERT_CLK(a_pop_moves, do_pop && !i_wr.push |=> r_count == $past(r_count) - 1'b1,
        "pop did not lower the count")

endmodule

@@ hw/rtl/fdss_back.sv @@
`include "assert_macros.svh"

module fdss_back
    import fdss_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_q_rd            i_rd,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [CMD_W-1:0] o_command_word,
    output logic             o_last_of_run
);

    t_pos             r_pos, n_pos;
    logic             r_out_valid, n_out_valid;
    logic [CMD_W-1:0] r_cmd, n_cmd;
    logic             r_last, n_last;

    logic             load;
    logic [DIGIT_W-1:0] digit;
    logic [SEG_W-1:0] seg;
    logic             is_last;

    assign load    = i_rd.valid && (!r_out_valid || !i_stall);
    assign is_last = (r_pos == P_ONES);
    assign o_pop   = load && is_last;

    always_comb begin
        case (r_pos)
            P_THOU:  digit = i_rd.entry.thou;
            P_HUND:  digit = i_rd.entry.hund;
            P_TENS:  digit = i_rd.entry.tens;
            default: digit = i_rd.entry.ones;
        endcase
        seg = seg_of(digit);
        if (r_pos == P_TENS && i_rd.entry.mode != MODE_NONE) begin
            seg = seg | POINT_BIT;
        end
    end

    always_comb begin
        n_pos       = r_pos;
        n_out_valid = r_out_valid;
        n_cmd       = r_cmd;
        n_last      = r_last;
        if (load) begin
            n_out_valid = 1'b1;
            n_cmd       = {CMD_BASE + {2'b00, r_pos}, seg};
            n_last      = is_last;
            case (r_pos)
                P_THOU:  n_pos = P_HUND;
                P_HUND:  n_pos = (i_rd.entry.mode == MODE_SKIP_TENS) ? P_ONES : P_TENS;
                P_TENS:  n_pos = P_ONES;
                default: n_pos = P_THOU;
            endcase
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= P_THOU;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_last <= n_last;
    end

    assign o_valid        = r_out_valid;
    assign o_command_word = r_cmd;
    assign o_last_of_run  = r_last;

    `ASSERT_CLK(a_last_is_ones, r_out_valid |-> (r_last == (r_cmd[CMD_W-1:SEG_W] == 4'hb)),
        "end of run not on the ones digit")
    `ASSERT_NEVER(a_skip_tens, load && r_pos == P_TENS && i_rd.entry.mode == MODE_SKIP_TENS,
        "tens word issued in skip mode")

endmodule
